// ===== rtl/core/lowest_free_index_allocator_assert.svh =====
// Assertion macros for the lowest free index allocator checker.
`ifndef LOWEST_FREE_INDEX_ALLOCATOR_ASSERT_SVH
`define LOWEST_FREE_INDEX_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFIA_CHK_NOW(lbl, clk, rst_n, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFIA_CHK_NEXT(lbl, clk, rst_n, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== rtl/core/lfia_pkg.sv =====
// Shared types and constants of the lowest free index allocator.
`timescale 1ns / 1ps
`default_nettype none

package lfia_pkg;

  localparam int unsigned MAX_SLOTS = 256;
  localparam int unsigned IDX_W     = 9;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned BIT_W     = $clog2(WORD_W);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [BIT_W-1:0]  bit_t;
  typedef logic [BIT_W:0]    run_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BADFREE = 2'd2
  } status_e;

  typedef struct packed {
    op_e  operation;
    idx_t slot_index;
  } req_t;

  typedef struct packed {
    idx_t    granted_index;
    status_e status;
    idx_t    slots_in_use;
  } rsp_t;

  // Result of evaluating one bitmap word
  typedef struct packed {
    logic found;
    bit_t low_bit;
    run_t run;
  } word_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfia_stream_if.sv =====
// Valid/ready stream interface used for the request and response channels.
`timescale 1ns / 1ps
`default_nettype none

interface lfia_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfia_word_unit.sv =====
// Shared bitmap word evaluator: lowest set bit below a limit and run of ones downward.
`timescale 1ns / 1ps
`default_nettype none

module lfia_word_unit (
  input  wire lfia_pkg::word_t word_i,
  input  wire lfia_pkg::bit_t  pos_i,
  input  wire                  whole_i,
  output lfia_pkg::word_res_t  res_o
);

  localparam int unsigned WordW = lfia_pkg::WORD_W;

  lfia_pkg::word_t mask;
  lfia_pkg::word_t masked;
  lfia_pkg::word_t aligned;
  lfia_pkg::bit_t  low_bit;
  lfia_pkg::run_t  run;
  logic            stop;

  // Valid bits are the whole word or those strictly below pos_i.
  assign mask    = whole_i ? '1 : ((lfia_pkg::word_t'(1) << pos_i) - lfia_pkg::word_t'(1));
  assign masked  = word_i & mask;
  // Move bit pos_i to the top so the downward run becomes a leading-ones count.
  assign aligned = word_i << (lfia_pkg::bit_t'(WordW - 1) - pos_i);

  always_comb begin
    low_bit = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (masked[i]) begin
        low_bit = lfia_pkg::bit_t'(i);
      end
    end
  end

  always_comb begin
    run  = '0;
    stop = 1'b0;
    for (int i = WordW - 1; i >= 0; i--) begin
      if (!stop && aligned[i]) begin
        run = run + lfia_pkg::run_t'(1);
      end else begin
        stop = 1'b1;
      end
    end
  end

  assign res_o.found   = |masked;
  assign res_o.low_bit = low_bit;
  assign res_o.run     = run;

endmodule

`default_nettype wire

// ===== rtl/core/lowest_free_index_allocator.sv =====
// Top level of the lowest free index allocator with a high-water mark.
//
//  Channel  Dir  Payload                                   Transfer
//  req_i    in   operation, slot_index                     valid & ready
//  rsp_o    out  granted_index, status, slots_in_use       valid & ready
//
// One transaction is in work at a time; req_i.ready is high only while idle.
// Steps: a free of a middle slot passes a free check, a new slot at the mark a
// raise step, a reuse a scan of bitmap words up to the first free bit, a free of
// the top slot a walk down from the lowered mark unless it is zero; a full table
// or a bad free goes straight out. The bitmap memory is read one 16-bit word per cycle.
// Reset clears the mark, the count and the other state but not the bitmap; bits
// at or above the mark are masked off on read, so no clearing pass runs. A
// stalled response holds in the output register; the sequencer waits for it in S_EMIT.
`timescale 1ns / 1ps
`default_nettype none

module lowest_free_index_allocator #(
  parameter int unsigned MaxSlots = lfia_pkg::MAX_SLOTS
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  lfia_stream_if.sink   req_i,
  lfia_stream_if.source rsp_o
);

  localparam int unsigned WordW = lfia_pkg::WORD_W;
  localparam int unsigned BitW  = lfia_pkg::BIT_W;
  localparam int unsigned IdxW  = lfia_pkg::IDX_W;
  localparam int unsigned SlotW = $clog2(MaxSlots + 1);
  localparam int unsigned Words = (MaxSlots + WordW - 1) / WordW;
  localparam int unsigned AddrW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned PosW  = AddrW + BitW;
  localparam int unsigned CmpW  = (SlotW > IdxW) ? SlotW : IdxW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RAISE,
    S_WALK,
    S_FREECHK,
    S_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic [SlotW-1:0]      hw_q, hw_d;      // high-water mark
  logic [SlotW-1:0]      fc_q, fc_d;      // free slots below the mark
  logic [AddrW-1:0]      ptr_q, ptr_d;    // word being scanned
  logic [PosW-1:0]       pos_q, pos_d;    // bit position under work
  logic [SlotW-1:0]      gnt_q, gnt_d;
  lfia_pkg::status_e     st_q, st_d;
  logic                  out_valid_q, out_valid_d;
  lfia_pkg::rsp_t        out_q, out_d;

  // Free bitmap: bit p set when slot p+1 is free and below the mark
  lfia_pkg::word_t       mem_q [Words];
  lfia_pkg::word_t       rdata_q;
  logic                  rd_en;
  logic [AddrW-1:0]      rd_addr;
  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  lfia_pkg::word_t       wr_data;

  logic [PosW-1:0]       hm1;        // position of the slot at the mark
  logic [AddrW-1:0]      hm1_word;
  lfia_pkg::bit_t        hm1_bit;
  logic [CmpW-1:0]       slot_c;
  logic [CmpW-1:0]       hw_c;
  logic [PosW-1:0]       slot_pos;
  logic [SlotW-1:0]      hw_dec;
  logic [PosW-1:0]       top_pos;    // position of the slot at the lowered mark
  logic [PosW-1:0]       found_pos;
  logic [SlotW-1:0]      run_slots;
  logic [SlotW-1:0]      hw_after;
  logic                  walk_more;

  lfia_pkg::bit_t        u_pos;
  logic                  u_whole;
  lfia_pkg::word_res_t   u_res;

  assign hm1      = PosW'(hw_q - SlotW'(1));
  assign hm1_word = hm1[PosW-1:BitW];
  assign hm1_bit  = hm1[BitW-1:0];
  assign slot_c   = CmpW'(req_i.data.slot_index);
  assign hw_c     = CmpW'(hw_q);
  assign slot_pos = PosW'(req_i.data.slot_index - lfia_pkg::idx_t'(1));
  assign hw_dec   = hw_q - SlotW'(1);
  assign top_pos  = PosW'(hw_dec - SlotW'(1));

  // Scan: full words below the mark word, partial mark word, nothing above.
  // Walk: the run starts at the slot at the current mark.
  assign u_whole = (ptr_q < hm1_word);
  assign u_pos   = ((state_q == S_WALK) || (ptr_q == hm1_word)) ? hm1_bit : '0;

  lfia_word_unit u_word (
    .word_i  (rdata_q),
    .pos_i   (u_pos),
    .whole_i (u_whole),
    .res_o   (u_res)
  );

  assign found_pos = {ptr_q, u_res.low_bit};
  assign run_slots = SlotW'(u_res.run);
  assign hw_after  = hw_q - run_slots;
  assign walk_more = (u_res.run == (lfia_pkg::run_t'(hm1_bit) + lfia_pkg::run_t'(1)))
                     && (hw_after != '0);

  always_comb begin
    state_d     = state_q;
    hw_d        = hw_q;
    fc_d        = fc_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    gnt_d       = gnt_q;
    st_d        = st_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rdata_q;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          gnt_d = '0;
          st_d  = lfia_pkg::ST_OK;
          if (req_i.data.operation == lfia_pkg::OP_ALLOC) begin
            if (fc_q != '0) begin
              // Reuse: scan from word 0 for the lowest free slot
              rd_en   = 1'b1;
              rd_addr = '0;
              ptr_d   = '0;
              state_d = S_SCAN;
            end else if (hw_c == CmpW'(MaxSlots)) begin
              st_d    = lfia_pkg::ST_FULL;
              state_d = S_EMIT;
            end else begin
              // Raise the mark; its bitmap bit must read as in use
              hw_d    = hw_q + SlotW'(1);
              gnt_d   = hw_q + SlotW'(1);
              pos_d   = PosW'(hw_q);
              rd_en   = 1'b1;
              rd_addr = hm1_word + AddrW'(hm1_bit == lfia_pkg::bit_t'(WordW - 1));
              state_d = S_RAISE;
            end
          end else begin
            if (slot_c == '0 || slot_c > hw_c) begin
              st_d    = lfia_pkg::ST_BADFREE;
              state_d = S_EMIT;
            end else if (slot_c == hw_c) begin
              // Lower the mark, then walk down past trailing free slots
              hw_d = hw_dec;
              if (hw_dec == '0) begin
                state_d = S_EMIT;
              end else begin
                rd_en   = 1'b1;
                rd_addr = top_pos[PosW-1:BitW];
                state_d = S_WALK;
              end
            end else begin
              pos_d   = slot_pos;
              rd_en   = 1'b1;
              rd_addr = slot_pos[PosW-1:BitW];
              state_d = S_FREECHK;
            end
          end
        end
      end

      S_SCAN: begin
        if (u_res.found) begin
          wr_en   = 1'b1;
          wr_addr = ptr_q;
          wr_data = rdata_q & ~(lfia_pkg::word_t'(1) << u_res.low_bit);
          fc_d    = fc_q - SlotW'(1);
          gnt_d   = SlotW'(found_pos) + SlotW'(1);
          state_d = S_EMIT;
        end else begin
          // Advance to the next word
          ptr_d   = ptr_q + AddrW'(1);
          rd_en   = 1'b1;
          rd_addr = ptr_q + AddrW'(1);
        end
      end

      S_RAISE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[PosW-1:BitW];
        wr_data = rdata_q & ~(lfia_pkg::word_t'(1) << pos_q[BitW-1:0]);
        state_d = S_EMIT;
      end

      S_WALK: begin
        // Trailing free bits stay in memory; the lowered mark masks them.
        hw_d = hw_after;
        fc_d = fc_q - run_slots;
        if (walk_more) begin
          rd_en   = 1'b1;
          rd_addr = hm1_word - AddrW'(1);
        end else begin
          state_d = S_EMIT;
        end
      end

      S_FREECHK: begin
        if (rdata_q[pos_q[BitW-1:0]]) begin
          st_d = lfia_pkg::ST_BADFREE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = pos_q[PosW-1:BitW];
          wr_data = rdata_q | (lfia_pkg::word_t'(1) << pos_q[BitW-1:0]);
          fc_d    = fc_q + SlotW'(1);
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d         = 1'b1;
          out_d.granted_index = lfia_pkg::idx_t'(gnt_q);
          out_d.status        = st_q;
          out_d.slots_in_use  = lfia_pkg::idx_t'(hw_q - fc_q);
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= '0;
      fc_q        <= '0;
      ptr_q       <= '0;
      pos_q       <= '0;
      gnt_q       <= '0;
      st_q        <= lfia_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      fc_q        <= fc_d;
      ptr_q       <= ptr_d;
      pos_q       <= pos_d;
      gnt_q       <= gnt_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign req_i.ready = (state_q == S_IDLE);
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/lfia_checker.sv =====
// Port-level assertion checker for the lowest free index allocator, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "lowest_free_index_allocator_assert.svh"

module lfia_checker #(
  parameter int unsigned MaxSlots = lfia_pkg::MAX_SLOTS
) (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 req_valid_i,
  input wire                 req_ready_i,
  input wire                 rsp_valid_i,
  input wire                 rsp_ready_i,
  input wire lfia_pkg::rsp_t rsp_data_i
);

  localparam int unsigned IdxW = lfia_pkg::IDX_W;

  `LFIA_CHK_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request accepted while previous transaction still in work")
  `LFIA_CHK_NOW(a_no_grant_on_error, clk_i, rst_ni, rsp_valid_i && (rsp_data_i.status != lfia_pkg::ST_OK), rsp_data_i.granted_index == '0, "error response carries a granted index")
  `LFIA_CHK_NOW(a_full_means_all_used, clk_i, rst_ni, rsp_valid_i && (rsp_data_i.status == lfia_pkg::ST_FULL), rsp_data_i.slots_in_use == IdxW'(MaxSlots), "table full reported with slots left")
  `LFIA_CHK_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_data_i), "stalled response dropped or changed")

endmodule

bind lowest_free_index_allocator lfia_checker #(
  .MaxSlots (MaxSlots)
) u_lfia_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

`default_nettype wire

// ===== dv/lowest_free_index_allocator_tb.sv =====
// Self-checking testbench of the lowest free index allocator.
`timescale 1ns / 1ps

module lowest_free_index_allocator_tb;
  import lfia_pkg::*;

  // Worst item: reuse scan over all 16 bitmap words, plus a long request gap and
  // a long response stall. About 450 items are sent; the limit allows several
  // times their total in that worst case.
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RANDOM_ITEMS = 170;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned NUM_ROWS     = 24;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_e;

  // One row of the directed table. The row repeats reps times. Where
  // golden_given is set, the typed response is expected instead of the
  // predicted one.
  typedef struct {
    op_e         op;
    idx_t        slot;
    int unsigned reps;
    bit          golden_given;
    rsp_t        golden;
  } step_row_t;

  logic clk_i;
  logic rst_ni;

  lfia_stream_if #(.payload_t(req_t)) req_if ();
  lfia_stream_if #(.payload_t(rsp_t)) rsp_if ();

  lowest_free_index_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Mirror of the allocator: free bit per slot below the mark, the mark,
  // and the number of free bits.
  bit          slot_is_free [1:MAX_SLOTS];
  int unsigned mark_level;
  int unsigned free_slots;

  rsp_t        pending_rsp_q [$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned rsp_stall_left;
  bit          calm_mode;
  step_row_t   directed_rows [NUM_ROWS];

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  // Apply one transaction to the mirror and return the response it yields.
  function automatic rsp_t predict_allocation(input req_t item);
    rsp_t        o;
    int unsigned s;
    bit          found;
    o.granted_index = '0;
    o.status        = ST_OK;
    if (item.operation == OP_ALLOC) begin
      found = 1'b0;
      // Reuse the lowest free slot below the mark first.
      for (s = 1; s < mark_level; s++) begin
        if (!found && slot_is_free[s]) begin
          slot_is_free[s] = 1'b0;
          free_slots--;
          o.granted_index = idx_t'(s);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (mark_level >= MAX_SLOTS) begin
          o.status = ST_FULL;
        end else begin
          mark_level++;
          o.granted_index = idx_t'(mark_level);
        end
      end
    end else begin
      s = item.slot_index;
      if (s == 0 || s > mark_level) begin
        o.status = ST_BADFREE;
      end else if (s == mark_level) begin
        // Lower the mark, then walk it down past trailing free slots.
        mark_level--;
        while (mark_level > 0 && slot_is_free[mark_level]) begin
          slot_is_free[mark_level] = 1'b0;
          free_slots--;
          mark_level--;
        end
      end else if (slot_is_free[s]) begin
        o.status = ST_BADFREE;
      end else begin
        slot_is_free[s] = 1'b1;
        free_slots++;
      end
    end
    o.slots_in_use = idx_t'(mark_level - free_slots);
    return o;
  endfunction

  // Mostly short gaps, now and then a long one; none in calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (calm_mode || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Pick a slot that is in use (slot 1 to 4 on an empty table), favoring the top slot so the mark walks.
  function automatic idx_t pick_busy_slot();
    int unsigned start;
    int unsigned k;
    int unsigned s;
    if (mark_level == 0) return idx_t'($urandom_range(1, 4));
    if ($urandom_range(0, 3) == 0) return idx_t'(mark_level);
    start = $urandom_range(1, mark_level);
    for (k = 0; k < mark_level; k++) begin
      s = ((start - 1 + k) % mark_level) + 1;
      if (!slot_is_free[s]) return idx_t'(s);
    end
    return idx_t'(mark_level);
  endfunction

  function automatic step_row_t row(input op_e op, input int unsigned slot,
                                    input int unsigned reps, input bit given,
                                    input int unsigned g_idx, input status_e g_st,
                                    input int unsigned g_use);
    step_row_t r;
    r.op                   = op;
    r.slot                 = idx_t'(slot);
    r.reps                 = reps;
    r.golden_given         = given;
    r.golden.granted_index = idx_t'(g_idx);
    r.golden.status        = g_st;
    r.golden.slots_in_use  = idx_t'(g_use);
    return r;
  endfunction

  // Drive one request transaction at the falling edge, hold it until it is
  // taken, then queue its expected response.
  task automatic send_request(input req_t item, input bit use_golden, input rsp_t golden);
    int unsigned gap;
    rsp_t        predicted;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.data  = item;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = predict_allocation(item);
    pending_rsp_q.push_back(use_golden ? golden : predicted);
  endtask

  // Drop valid so the last transaction is not taken again, then wait.
  task automatic wait_all_responses();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // Response side: stall at random, sampled back at the rising edge.
  initial rsp_if.ready = 1'b0;

  always @(negedge clk_i) begin
    if (rsp_stall_left != 0) begin
      rsp_if.ready = 1'b0;
      rsp_stall_left--;
    end else begin
      rsp_stall_left = pick_gap();
      rsp_if.ready   = (rsp_stall_left == 0);
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    rsp_t got;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (pending_rsp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected response idx=%0d status=%0d in_use=%0d",
                                  got.granted_index, got.status, got.slots_in_use));
      end else begin
        want = pending_rsp_q.pop_front();
        if (got.granted_index !== want.granted_index)
          report_mismatch($sformatf("granted_index got %0d want %0d",
                                    got.granted_index, want.granted_index));
        if (got.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
        if (got.slots_in_use !== want.slots_in_use)
          report_mismatch($sformatf("slots_in_use got %0d want %0d",
                                    got.slots_in_use, want.slots_in_use));
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk_i);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    req_t        item;
    rsp_t        no_golden;
    phase_e      phase;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned i;
    int unsigned k;
    bit          do_alloc;

    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.data    = '0;
    calm_mode      = 1'b0;
    rsp_stall_left = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    mark_level     = 0;
    free_slots     = 0;
    no_golden      = '0;
    for (i = 1; i <= MAX_SLOTS; i++) slot_is_free[i] = 1'b0;

    // Directed part: bad frees on an empty table, first grants, reuse, a top
    // free walking the mark, fill to full, then walks and refills at the top.
    directed_rows = '{
      row(OP_FREE,    0,   1, 1, 0, ST_BADFREE, 0),
      row(OP_FREE,  256,   1, 1, 0, ST_BADFREE, 0),
      row(OP_FREE,  511,   1, 1, 0, ST_BADFREE, 0),
      row(OP_ALLOC, 511,   1, 1, 1, ST_OK,      1),
      row(OP_ALLOC,   0,   1, 1, 2, ST_OK,      2),
      row(OP_ALLOC, 341,   1, 1, 3, ST_OK,      3),
      row(OP_FREE,    1,   1, 1, 0, ST_OK,      2),
      row(OP_FREE,    1,   1, 1, 0, ST_BADFREE, 2),
      row(OP_ALLOC,   0,   1, 1, 1, ST_OK,      3),
      row(OP_FREE,    2,   1, 0, 0, ST_OK,      0),
      row(OP_FREE,    3,   1, 0, 0, ST_OK,      0),
      row(OP_FREE,    4,   1, 1, 0, ST_BADFREE, 1),
      row(OP_ALLOC,   0, 255, 0, 0, ST_OK,      0),
      row(OP_ALLOC,   0,   1, 1, 0, ST_FULL,    256),
      row(OP_FREE,  256,   1, 1, 0, ST_OK,      255),
      row(OP_FREE,  100,   1, 0, 0, ST_OK,      0),
      row(OP_FREE,  253,   1, 0, 0, ST_OK,      0),
      row(OP_FREE,  255,   1, 0, 0, ST_OK,      0),
      row(OP_FREE,  254,   1, 0, 0, ST_OK,      0),
      row(OP_ALLOC, 511,   1, 0, 0, ST_OK,      0),
      row(OP_ALLOC,   0,   4, 0, 0, ST_OK,      0),
      row(OP_ALLOC,   0,   1, 1, 0, ST_FULL,    256),
      row(OP_FREE,  257,   1, 1, 0, ST_BADFREE, 256),
      row(OP_FREE,    0,   1, 1, 0, ST_BADFREE, 256)
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (i = 0; i < NUM_ROWS; i++) begin
      for (k = 0; k < directed_rows[i].reps; k++) begin
        item.operation  = directed_rows[i].op;
        item.slot_index = directed_rows[i].slot;
        send_request(item, directed_rows[i].golden_given, directed_rows[i].golden);
      end
    end

    // Hold off until the block has answered everything.
    wait_all_responses();

    // Random part: phases that fill, drain or mix the table, plus some noise.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      k = $urandom_range(0, 9);
      if (k < 3)      phase = PH_FILL;
      else if (k < 6) phase = PH_DRAIN;
      else if (k < 9) phase = PH_MIXED;
      else            phase = PH_NOISE;
      phase_len = $urandom_range(10, 50);
      calm_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 5) == 0) wait_all_responses();
      for (i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        k = $urandom_range(0, 99);
        case (phase)
          PH_FILL:  do_alloc = (k < 85);
          PH_DRAIN: do_alloc = (k < 15);
          PH_MIXED: do_alloc = (k < 50);
          default:  do_alloc = (k < 50);
        endcase
        item.operation = do_alloc ? OP_ALLOC : OP_FREE;
        if (do_alloc) begin
          item.slot_index = idx_t'($urandom_range(0, 511));
        end else if (phase == PH_NOISE) begin
          item.slot_index = ($urandom_range(0, 3) == 0) ? idx_t'($urandom_range(0, 511))
                                                        : idx_t'($urandom_range(0, mark_level + 2));
        end else if (phase == PH_MIXED && $urandom_range(0, 4) == 0) begin
          // Free anything from slot 0 to one above the mark, already-free slots included.
          item.slot_index = idx_t'($urandom_range(0, mark_level + 1));
        end else begin
          item.slot_index = pick_busy_slot();
        end
        send_request(item, 1'b0, no_golden);
        sent++;
      end
    end

    @(negedge clk_i);
    req_if.valid = 1'b0;
    calm_mode    = 1'b0;
    wait_all_responses();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/lfia_pkg.sv
rtl/core/lfia_stream_if.sv
rtl/core/lfia_word_unit.sv
rtl/core/lowest_free_index_allocator.sv
rtl/core/lfia_checker.sv
dv/lowest_free_index_allocator_tb.sv
